[hdl/pdbq_pkg.sv]
package pdbq_pkg;

    localparam int PDBQ_DESTS  = 16;
    localparam int PDBQ_QDEPTH = 64;

    localparam int DEST_W    = 4;
    localparam int PKT_W     = 16;
    localparam int CNT_W     = 7;
    localparam int SCORE_W   = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] QUEUE_LIMIT_RESET     = 7'd50;
    localparam logic [CFG_W-1:0] NEIGHBOR_LENGTH_RESET = 7'd21;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUEUE_LIMIT,
        REG_NEIGHBOR_LENGTH
    } cfg_reg_t;

    typedef enum logic {
        CMD_ENQ,
        CMD_DEQ
    } cmd_t;

    typedef enum logic [1:0] {
        ST_ENQUEUED,
        ST_DROPPED,
        ST_DEQUEUED,
        ST_EMPTY
    } status_t;

    typedef enum logic [1:0] {
        SEL_DEST,
        SEL_SCAN,
        SEL_BEST
    } idx_sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_SCAN,
        S_PICK,
        S_DEQ_OUT
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     scan_step;
        logic     enq_commit;
        logic     deq_read;
        logic     deq_commit;
        logic     empty_commit;
        idx_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic found;
        logic slot_free;
    } dp_stat_t;

endpackage

[hdl/pdbq_req_if.sv]
interface pdbq_req_if import pdbq_pkg::*; ();
    logic              valid;
    logic              ready;
    cmd_t              cmd;
    logic [DEST_W-1:0] dest;
    logic [PKT_W-1:0]  pkt_id;

    modport source (output valid, output cmd, output dest, output pkt_id, input ready);
    modport sink   (input valid, input cmd, input dest, input pkt_id, output ready);
endinterface

[hdl/pdbq_rsp_if.sv]
interface pdbq_rsp_if import pdbq_pkg::*; ();
    logic               valid;
    logic               ready;
    status_t            status;
    logic [PKT_W-1:0]   out_pkt;
    logic [DEST_W-1:0]  out_dest;
    logic [SCORE_W-1:0] score;

    modport source (output valid, output status, output out_pkt, output out_dest,
                    output score, input ready);
    modport sink   (input valid, input status, input out_pkt, input out_dest,
                    input score, output ready);
endinterface

[hdl/pdbq_ram.sv]
module pdbq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/pdbq_ctrl.sv]
module pdbq_ctrl import pdbq_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  cmd_t     req_cmd,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.sel    = SEL_DEST;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = (req_cmd == CMD_DEQ) ? S_SCAN : S_ENQ;
                end
            end
            S_ENQ:
            begin
                ctl.sel = SEL_DEST;
                if (stat.slot_free)
                begin
                    ctl.enq_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN:
            begin
                ctl.sel       = SEL_SCAN;
                ctl.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                ctl.sel = SEL_BEST;
                if (stat.found)
                begin
                    ctl.deq_read = 1'b1;
                    state_next   = S_DEQ_OUT;
                end
                else if (stat.slot_free)
                begin
                    ctl.empty_commit = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_DEQ_OUT:
            begin
                ctl.sel = SEL_BEST;
                if (stat.slot_free)
                begin
                    ctl.deq_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/pdbq_dp.sv]
module pdbq_dp import pdbq_pkg::*; #(
    parameter int DESTS  = PDBQ_DESTS,
    parameter int QDEPTH = PDBQ_QDEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  cmd_t                 req_cmd,
    input  logic [DEST_W-1:0]    req_dest,
    input  logic [PKT_W-1:0]     req_pkt_id,
    input  logic                 rsp_ready,
    input  dp_cmd_t              ctl,
    output dp_stat_t             stat,
    output logic                 rsp_valid,
    output status_t              rsp_status,
    output logic [PKT_W-1:0]     rsp_out_pkt,
    output logic [DEST_W-1:0]    rsp_out_dest,
    output logic [SCORE_W-1:0]   rsp_score
);

    localparam int DW    = $clog2(DESTS);
    localparam int PW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int DXW   = (DW > DEST_W) ? DW : DEST_W;
    localparam int DEPTH = DESTS * QDEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int QCW   = $clog2(QDEPTH + 1);
    localparam int CW    = (QCW > CNT_W) ? QCW : CNT_W;
    localparam int SW    = ((PW > CNT_W) ? PW : CNT_W) + 1;

    // captured request
    cmd_t              cmd_reg;
    logic [DEST_W-1:0] dest_reg;
    logic [PKT_W-1:0]  pkt_reg;

    logic [CFG_W-1:0] queue_limit_reg;
    logic [CFG_W-1:0] neighbor_reg;

    logic [CNT_W-1:0] count_reg [DESTS];
    logic [PW-1:0]    head_reg  [DESTS];

    logic [DW-1:0]      scan_idx_reg;
    logic [DW-1:0]      best_reg;
    logic [SCORE_W-1:0] best_score_reg;
    logic               found_reg;

    logic               rsp_valid_reg;
    status_t            rsp_status_reg;
    logic [PKT_W-1:0]   rsp_pkt_reg;
    logic [DEST_W-1:0]  rsp_dest_reg;
    logic [SCORE_W-1:0] rsp_score_reg;

    logic [DXW-1:0]     dest_ext;
    logic [DW-1:0]      dest_idx;
    logic [DW-1:0]      sel_idx;
    logic [CNT_W-1:0]   count_sel;
    logic [PW-1:0]      head_sel;
    logic [PW-1:0]      head_inc;
    logic [SCORE_W-1:0] score_sel;
    logic               better;
    logic [CW-1:0]      cap;
    logic               dest_oor;
    logic               drop;
    logic [SW-1:0]      pos_sum;
    logic [PW-1:0]      pos;
    logic [AW-1:0]      base;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [PKT_W-1:0]   ram_rdata;
    logic               commit;

    assign dest_ext = DXW'(dest_reg);
    assign dest_idx = dest_ext[DW-1:0];

    always_comb
    begin
        case (ctl.sel)
            SEL_DEST: sel_idx = dest_idx;
            SEL_SCAN: sel_idx = scan_idx_reg;
            SEL_BEST: sel_idx = best_reg;
            default:  sel_idx = dest_idx;
        endcase
    end

    assign count_sel = count_reg[sel_idx];
    assign head_sel  = head_reg[sel_idx];

    assign score_sel = (count_sel >= neighbor_reg) ? SCORE_W'(count_sel - neighbor_reg)
                                                   : SCORE_W'(neighbor_reg - count_sel);
    assign better    = (count_sel != '0) && (!found_reg || (score_sel > best_score_reg));

    assign cap      = (CW'(queue_limit_reg) < CW'(QDEPTH)) ? CW'(queue_limit_reg)
                                                           : CW'(QDEPTH);
    assign dest_oor = (32'(dest_reg) >= 32'(DESTS));
    assign drop     = dest_oor || (CW'(count_sel) >= cap);

    // head + count stays below twice the depth: one subtract wraps it
    assign pos_sum  = SW'(head_sel) + SW'(count_sel);
    assign pos      = (pos_sum >= SW'(QDEPTH)) ? PW'(pos_sum - SW'(QDEPTH)) : PW'(pos_sum);
    assign head_inc = (32'(head_sel) == 32'(QDEPTH - 1)) ? '0 : head_sel + 1'b1;

    assign base      = AW'(sel_idx) * AW'(QDEPTH);
    assign ram_we    = ctl.enq_commit && !drop;
    assign ram_waddr = base + AW'(pos);
    assign ram_raddr = base + AW'(head_sel);

    pdbq_ram #(
        .WIDTH (PKT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pkt_reg),
        .re    (ctl.deq_read),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= req_cmd;
            dest_reg <= req_dest;
            pkt_reg  <= req_pkt_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_limit_reg <= QUEUE_LIMIT_RESET;
            neighbor_reg    <= NEIGHBOR_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_QUEUE_LIMIT:     queue_limit_reg <= cfg_data;
                REG_NEIGHBOR_LENGTH: neighbor_reg    <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DESTS; i++)
            begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
            end
        end
        else if (ram_we)
        begin
            count_reg[sel_idx] <= count_sel + 1'b1;
        end
        else if (ctl.deq_commit)
        begin
            count_reg[sel_idx] <= count_sel - 1'b1;
            head_reg[sel_idx]  <= head_inc;
        end
    end

    // running maximum over the destinations, one per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            best_reg       <= '0;
            best_score_reg <= '0;
        end
        else if (ctl.capture)
        begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (ctl.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (better)
            begin
                found_reg      <= 1'b1;
                best_reg       <= scan_idx_reg;
                best_score_reg <= score_sel;
            end
        end
    end

    assign commit = ctl.enq_commit || ctl.deq_commit || ctl.empty_commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.enq_commit)
        begin
            rsp_status_reg <= drop ? ST_DROPPED : ST_ENQUEUED;
            rsp_pkt_reg    <= drop ? pkt_reg : '0;
            rsp_dest_reg   <= dest_reg;
            rsp_score_reg  <= '0;
        end
        else if (ctl.deq_commit)
        begin
            rsp_status_reg <= ST_DEQUEUED;
            rsp_pkt_reg    <= ram_rdata;
            rsp_dest_reg   <= DEST_W'(best_reg);
            rsp_score_reg  <= best_score_reg;
        end
        else if (ctl.empty_commit)
        begin
            rsp_status_reg <= ST_EMPTY;
            rsp_pkt_reg    <= '0;
            rsp_dest_reg   <= '0;
            rsp_score_reg  <= '0;
        end
    end

    assign stat.scan_last = (32'(scan_idx_reg) == 32'(DESTS - 1));
    assign stat.found     = found_reg;
    assign stat.slot_free = !rsp_valid_reg || rsp_ready;

    assign rsp_valid    = rsp_valid_reg;
    assign rsp_status   = rsp_status_reg;
    assign rsp_out_pkt  = rsp_pkt_reg;
    assign rsp_out_dest = rsp_dest_reg;
    assign rsp_score    = rsp_score_reg;

    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (!rsp_valid_reg || rsp_ready))
        else $error("result loaded over an untaken result");

    a_one_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.enq_commit, ctl.deq_commit, ctl.empty_commit}))
        else $error("more than one result in a cycle");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.deq_commit |-> (count_sel != '0) && (score_sel == best_score_reg))
        else $error("pop from an empty queue or score mismatch");

    a_read_found: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.deq_read |-> found_reg && (cmd_reg == CMD_DEQ))
        else $error("store read without a scan winner");

endmodule

[hdl/per_destination_backpressure_queue_unit.sv]
// Per-destination packet queue with differential dequeue scheduling. Each of
// DESTS destinations owns a ring of QDEPTH 16-bit handles in one shared
// store. An enqueue (cmd 0) appends pkt_id to queue dest, or tail-drops it
// when that queue holds min(queue_limit, QDEPTH) handles or dest is out of
// range. A dequeue (cmd 1) scores every non-empty queue as
// |length - neighbor_length| and pops the head of the best one, lowest index
// winning ties; with all queues empty it reports nothing queued. Every
// request produces exactly one result transfer. One request is in work at a
// time: an enqueue commits from S_ENQ; a dequeue runs the length scan that
// visits one destination per cycle, then the pick and the registered store
// read. The result sits in an output register, so the next request is
// accepted while a result waits; a waiting result holds the block only when
// the next result is ready. Configuration (index 0 queue_limit, index 1
// neighbor_length) must be written while idle; the block does not enforce it.
module per_destination_backpressure_queue_unit import pdbq_pkg::*; #(
    parameter int DESTS  = PDBQ_DESTS,
    parameter int QDEPTH = PDBQ_QDEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    pdbq_req_if.sink             req,
    pdbq_rsp_if.source           rsp
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    // sequencer: accept, scan, pick, commit
    pdbq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // queue state, handle store, scan registers and the result register
    pdbq_dp #(
        .DESTS  (DESTS),
        .QDEPTH (QDEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_cmd      (req.cmd),
        .req_dest     (req.dest),
        .req_pkt_id   (req.pkt_id),
        .rsp_ready    (rsp.ready),
        .ctl          (ctl),
        .stat         (stat),
        .rsp_valid    (rsp.valid),
        .rsp_status   (rsp.status),
        .rsp_out_pkt  (rsp.out_pkt),
        .rsp_out_dest (rsp.out_dest),
        .rsp_score    (rsp.score)
    );

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
    import pdbq_pkg::*;

    // Tolerate this many cycles without any transfer before giving up.
    localparam int WATCHDOG_LIMIT = 2000;
    // Longest request is a dequeue: a scan over every destination plus the store read.
    localparam int DRAIN_CYCLES   = PDBQ_DESTS + 3 + 8;

    // One result transfer as the block presents it.
    typedef struct packed {
        status_t            status;
        logic [PKT_W-1:0]   out_pkt;
        logic [DEST_W-1:0]  out_dest;
        logic [SCORE_W-1:0] score;
    } queue_result_t;

    // Mirror of the per-destination rings: keeps its own copy of the handles,
    // read positions, fill counts and registers, and the results still owed.
    class dest_queue_mirror;
        logic [PKT_W-1:0] slot_mem [PDBQ_DESTS][PDBQ_QDEPTH];
        int unsigned      rd_ptr [PDBQ_DESTS];
        int unsigned      depth [PDBQ_DESTS];
        int unsigned      limit;
        int unsigned      nbr_len;
        queue_result_t    pending_results [$];
        int               failures;

        function new();
            for (int i = 0; i < PDBQ_DESTS; i++)
            begin
                rd_ptr[i] = 0;
                depth[i]  = 0;
            end
            limit    = 32'(QUEUE_LIMIT_RESET);
            nbr_len  = 32'(NEIGHBOR_LENGTH_RESET);
            failures = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_QUEUE_LIMIT:     limit = 32'(val);
                REG_NEIGHBOR_LENGTH: nbr_len = 32'(val);
                default: ;
            endcase
        endfunction

        // Work out the result of one accepted request and queue it.
        function void note_request(cmd_t op, logic [DEST_W-1:0] d, logic [PKT_W-1:0] p);
            queue_result_t r;
            int unsigned   cap;
            int unsigned   slot;
            int            best;
            int            best_score;
            int            s;
            r.status   = ST_ENQUEUED;
            r.out_pkt  = '0;
            r.out_dest = '0;
            r.score    = '0;
            if (op == CMD_ENQ)
            begin
                cap = (limit < PDBQ_QDEPTH) ? limit : PDBQ_QDEPTH;
                r.out_dest = d;
                if (int'(d) >= PDBQ_DESTS || depth[d] >= cap)
                begin
                    r.status  = ST_DROPPED;
                    r.out_pkt = p;
                end
                else
                begin
                    slot = (rd_ptr[d] + depth[d]) % PDBQ_QDEPTH;
                    slot_mem[d][slot] = p;
                    depth[d]++;
                end
            end
            else
            begin
                best       = -1;
                best_score = 0;
                for (int i = 0; i < PDBQ_DESTS; i++)
                begin
                    if (depth[i] != 0)
                    begin
                        s = int'(depth[i]) - int'(nbr_len);
                        if (s < 0)
                            s = -s;
                        if (s > 127)
                            s = 127;
                        if (best < 0 || s > best_score)
                        begin
                            best       = i;
                            best_score = s;
                        end
                    end
                end
                if (best < 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.status   = ST_DEQUEUED;
                    r.out_pkt  = slot_mem[best][rd_ptr[best]];
                    r.out_dest = DEST_W'(best);
                    r.score    = SCORE_W'(best_score);
                    rd_ptr[best] = (rd_ptr[best] + 1) % PDBQ_QDEPTH;
                    depth[best]--;
                end
            end
            pending_results = {pending_results, r};
        endfunction

        function void compare_field(string field, logic [PKT_W-1:0] exp_v,
                                    logic [PKT_W-1:0] act_v);
            if (act_v !== exp_v)
            begin
                $error("%s mismatch: expected %0h, actual %0h", field, exp_v, act_v);
                failures++;
            end
        endfunction

        // Compare one accepted result with the oldest one owed.
        function void check_result(status_t st, logic [PKT_W-1:0] pkt,
                                   logic [DEST_W-1:0] d, logic [SCORE_W-1:0] sc);
            queue_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing outstanding: status %0h pkt %0h",
                       st, pkt);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", PKT_W'(want.status), PKT_W'(st));
            compare_field("out_pkt", want.out_pkt, pkt);
            compare_field("out_dest", PKT_W'(want.out_dest), PKT_W'(d));
            compare_field("score", PKT_W'(want.score), PKT_W'(sc));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    bit                   req_burst;
    bit                   rsp_burst;

    pdbq_req_if req_ch ();
    pdbq_rsp_if rsp_ch ();

    dest_queue_mirror mirror;

    per_destination_backpressure_queue_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // Enter and leave at a falling edge. Hold valid high across back-to-back
    // transfers so it never sees two updates in one step.
    task automatic send_request(input cmd_t op, input logic [DEST_W-1:0] d,
                                input logic [PKT_W-1:0] p);
        int gap;
        gap = req_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.cmd    <= op;
        req_ch.dest   <= d;
        req_ch.pkt_id <= p;
        do
            @(posedge clk);
        while (!req_ch.ready);
        mirror.note_request(op, d, p);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every owed result has been taken.
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (mirror.pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Pulse the write enable for one cycle, then drop it before returning.
    task automatic write_register(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        mirror.set_register(idx, val);
        @(negedge clk);
    endtask

    // Reprogram both registers with the block idle.
    task automatic apply_settings(input logic [CFG_W-1:0] lim, input logic [CFG_W-1:0] nbr);
        wait_for_results();
        repeat (2) @(negedge clk);
        write_register(REG_QUEUE_LIMIT, lim);
        write_register(REG_NEIGHBOR_LENGTH, nbr);
    endtask

    // Random traffic: enq_pct sets the enqueue share, hot_pct the share of
    // requests aimed at destinations 0..hot_max so that rings fill and wrap.
    task automatic run_phase(input int n_items, input int enq_pct, input int hot_pct,
                             input int hot_max);
        cmd_t              op;
        logic [DEST_W-1:0] d;
        for (int k = 0; k < n_items; k++)
        begin
            // Now and then let the block drain completely mid-phase.
            if ($urandom_range(0, 99) == 0)
                wait_for_results();
            op = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            if ($urandom_range(0, 99) < hot_pct)
                d = DEST_W'($urandom_range(0, hot_max));
            else
                d = DEST_W'($urandom());
            send_request(op, d, PKT_W'($urandom()));
        end
    endtask

    // Result side: draw a stall per result, keep ready high through bursts.
    initial
    begin
        int gap;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            gap = rsp_burst ? 0 : $urandom_range(0, 18);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            mirror.check_result(rsp_ch.status, rsp_ch.out_pkt, rsp_ch.out_dest,
                                rsp_ch.score);
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (req_ch.valid && req_ch.ready)
                || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        mirror = new();
        // Drive every input to a known value before the first edge.
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_QUEUE_LIMIT;
        cfg_data      = '0;
        req_ch.valid  = 1'b0;
        req_ch.cmd    = CMD_ENQ;
        req_ch.dest   = '0;
        req_ch.pkt_id = '0;
        req_burst     = 1'b0;
        rsp_burst     = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty dequeue, field extremes, tie on score resolved to
        // the lowest destination, drain back to empty.
        apply_settings(7'd50, 7'd21);
        send_request(CMD_DEQ, 4'd9, 16'hFFFF);
        send_request(CMD_ENQ, 4'd0, 16'h0000);
        send_request(CMD_ENQ, 4'd15, 16'hFFFF);
        send_request(CMD_ENQ, 4'd5, 16'hA5A5);
        send_request(CMD_ENQ, 4'd10, 16'h5A5A);
        send_request(CMD_ENQ, 4'd5, 16'h1234);
        repeat (6) send_request(CMD_DEQ, 4'd0, 16'h0000);

        // Zero limit: even the first packet of a destination is dropped.
        apply_settings(7'd0, 7'd0);
        send_request(CMD_ENQ, 4'd3, 16'h7FFF);
        send_request(CMD_DEQ, 4'd3, 16'h0000);

        // Limit of two: third packet dropped; far neighbor length favors the
        // shorter ring.
        apply_settings(7'd2, 7'd64);
        send_request(CMD_ENQ, 4'd7, 16'h8000);
        send_request(CMD_ENQ, 4'd7, 16'h0001);
        send_request(CMD_ENQ, 4'd7, 16'hFFFE);
        send_request(CMD_ENQ, 4'd1, 16'h4321);
        repeat (4) send_request(CMD_DEQ, 4'd15, 16'hFFFF);

        // Random phases over a spread of settings, extremes included.
        apply_settings(7'd64, 7'd0);
        req_burst = 1'b1;
        rsp_burst = 1'b0;
        run_phase(400, 60, 80, 0);

        apply_settings(7'd127, 7'd127);
        req_burst = 1'b0;
        rsp_burst = 1'b1;
        run_phase(150, 55, 20, 3);

        apply_settings(7'd64, 7'd64);
        req_burst = ($urandom_range(0, 3) == 0);
        rsp_burst = ($urandom_range(0, 3) == 0);
        run_phase(150, 50, 30, 3);

        apply_settings(7'd3, 7'd2);
        req_burst = 1'b1;
        rsp_burst = 1'b1;
        run_phase(150, 60, 40, 3);

        apply_settings(7'd1, 7'd0);
        req_burst = 1'b0;
        rsp_burst = 1'b0;
        run_phase(100, 50, 0, 0);

        apply_settings(7'd0, 7'd10);
        run_phase(50, 70, 0, 0);

        apply_settings(7'd50, 7'd21);
        req_burst = ($urandom_range(0, 3) == 0);
        rsp_burst = ($urandom_range(0, 3) == 0);
        run_phase(100, 55, 30, 1);

        repeat (2)
        begin
            apply_settings(CFG_W'($urandom_range(0, 127)), CFG_W'($urandom_range(0, 64)));
            req_burst = ($urandom_range(0, 3) == 0);
            rsp_burst = ($urandom_range(0, 3) == 0);
            run_phase(100, $urandom_range(30, 70), 40, 2);
        end

        // Take every owed result, then watch a little longer for strays.
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.pending_results.size() != 0)
        begin
            $error("%0d results never arrived", mirror.pending_results.size());
            mirror.failures++;
        end
        if (mirror.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
hdl/pdbq_pkg.sv
hdl/pdbq_req_if.sv
hdl/pdbq_rsp_if.sv
hdl/pdbq_ram.sv
hdl/pdbq_ctrl.sv
hdl/pdbq_dp.sv
hdl/per_destination_backpressure_queue_unit.sv
dv/tb.sv
